### design/idv_pkg.sv
package idv_pkg;

  localparam int IdLen      = 18;
  localparam int PosSat     = 19;
  localparam int DigitCount = 17;
  localparam int GenderPos  = 16;
  localparam int RegionEnd  = 6;
  localparam int CentEnd    = 8;
  localparam int YearEnd    = 10;
  localparam int MonthEnd   = 12;
  localparam int DayEnd     = 14;

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;
  localparam logic [7:0] CharUpX   = 8'd88;
  localparam logic [6:0] MonthFeb  = 7'd2;
  localparam logic [6:0] MonthDec  = 7'd12;

  localparam logic [3:0] WEIGHT [DigitCount] = '{
    4'd7, 4'd9, 4'd10, 4'd5, 4'd8, 4'd4, 4'd2, 4'd1, 4'd6,
    4'd3, 4'd7, 4'd9, 4'd10, 4'd5, 4'd8, 4'd4, 4'd2
  };

  localparam logic [7:0] CHECK_CODE [11] = '{
    8'd49, 8'd48, 8'd88, 8'd57, 8'd56, 8'd55, 8'd54, 8'd53, 8'd52, 8'd51, 8'd50
  };

  typedef struct packed {
    logic [4:0]  pos;
    logic [3:0]  wsum;
    logic        bad;
    logic [13:0] year;
    logic [6:0]  cent;
    logic [6:0]  yy;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [19:0] region;
    logic        gender;
    logic [7:0]  check;
  } acc_t;

  // Residue modulo 11 of a value up to 100: the quotient estimate from the
  // reciprocal 93/1024 is at most one low, so a single correction suffices.
  function automatic logic [3:0] mod11(input logic [6:0] x);
    logic [13:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 14'(x) * 14'd93;
    q    = prod[13:10];
    r    = x - 7'(q * 7'd11);
    if (r >= 7'd11) begin
      r = r - 7'd11;
    end
    return r[3:0];
  endfunction

  function automatic logic [6:0] month_limit(input logic [6:0] month, input logic leap);
    logic [6:0] lim;
    case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: lim = 7'd31;
      MonthFeb: lim = leap ? 7'd29 : 7'd28;
      default: lim = 7'd30;
    endcase
    return lim;
  endfunction

endpackage

### design/id_number_validator_core.sv
// Resident ID number validator, 18-character form.
//
// The input channel (char_valid, char_stall, char_code, last_char) carries
// one ASCII character per word; last_char marks the final character of a
// string. Every accepted word updates the running accumulators; the word
// with last_char set closes the string and produces exactly one result word.
//
// The result channel (result_valid, result_stall and the verdict and field
// ports) presents the verdicts and decoded fields of one string. A closed
// string moves from the internal register into the result register, and
// the block takes one character in every cycle while char_stall is low,
// including the cycle after a closing one. The checksum is kept modulo 11
// as the characters arrive, so the final stage needs only small compares.
//
// Reset clears the accumulators and empties both pipeline registers. While
// the receiver stalls, the result word holds; one further closed string
// waits in the internal register, and then char_stall rises until the
// result is taken.
module id_number_validator_core
  import idv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        id_valid,
  output logic        length_ok,
  output logic        chars_ok,
  output logic        date_ok,
  output logic        check_ok,
  output logic        is_male,
  output logic [13:0] birth_year,
  output logic [6:0]  birth_month,
  output logic [6:0]  birth_day,
  output logic [19:0] region_code
);

  acc_t acc;
  acc_t acc_next;
  acc_t fin;
  logic fin_valid;
  logic out_en;
  logic take;
  logic dig;
  logic [3:0] d;
  logic [7:0] prod;

  logic len_ok_c;
  logic chr_ok_c;
  logic dt_ok_c;
  logic ck_ok_c;
  logic leap;
  logic [6:0] lim;

  assign out_en     = !result_valid || !result_stall;
  assign char_stall = fin_valid && !out_en;
  assign take       = char_valid && !char_stall;

  always_comb begin
    acc_next = acc;
    dig      = (char_code inside {[CharZero:CharNine]});
    d        = dig ? 4'(char_code - CharZero) : 4'd0;
    prod     = '0;
    if (acc.pos < 5'(DigitCount)) begin
      prod          = 8'(d) * 8'(WEIGHT[acc.pos]);
      acc_next.bad  = acc.bad | !dig;
      acc_next.wsum = mod11(7'(acc.wsum) + prod[6:0]);
      if (acc.pos < 5'(RegionEnd)) begin
        acc_next.region = 20'(acc.region * 20'd10 + 20'(d));
      end else if (acc.pos < 5'(YearEnd)) begin
        acc_next.year = 14'(acc.year * 14'd10 + 14'(d));
        if (acc.pos < 5'(CentEnd)) begin
          acc_next.cent = 7'(acc.cent * 7'd10 + 7'(d));
        end else begin
          acc_next.yy = 7'(acc.yy * 7'd10 + 7'(d));
        end
      end else if (acc.pos < 5'(MonthEnd)) begin
        acc_next.month = 7'(acc.month * 7'd10 + 7'(d));
      end else if (acc.pos < 5'(DayEnd)) begin
        acc_next.day = 7'(acc.day * 7'd10 + 7'(d));
      end
      if (acc.pos == 5'(GenderPos)) begin
        acc_next.gender = d[0];
      end
    end else if (acc.pos == 5'(DigitCount)) begin
      acc_next.bad   = acc.bad | (!dig && (char_code != CharUpX));
      acc_next.check = char_code;
    end
    if (acc.pos < 5'(PosSat)) begin
      acc_next.pos = acc.pos + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (take) begin
      acc <= last_char ? '0 : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (!fin_valid || out_en) begin
      fin_valid <= take && last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (take && last_char) begin
      fin <= acc_next;
    end
  end

  // Verdicts on length, characters, date and check character; leap year from the century and the year within it.
  always_comb begin
    len_ok_c = (fin.pos == 5'(IdLen));
    chr_ok_c = !fin.bad;
    leap     = (fin.yy == 7'd0) ? (fin.cent[1:0] == 2'd0) : (fin.yy[1:0] == 2'd0);
    lim      = month_limit(fin.month, leap);
    dt_ok_c  = (fin.month >= 7'd1) && (fin.month <= MonthDec) &&
               (fin.day >= 7'd1) && (fin.day <= lim);
    ck_ok_c  = len_ok_c && (fin.check == CHECK_CODE[fin.wsum]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_en) begin
      result_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && fin_valid) begin
      id_valid    <= len_ok_c && chr_ok_c && dt_ok_c && ck_ok_c;
      length_ok   <= len_ok_c;
      chars_ok    <= chr_ok_c;
      date_ok     <= dt_ok_c;
      check_ok    <= ck_ok_c;
      is_male     <= fin.gender;
      birth_year  <= fin.year;
      birth_month <= fin.month;
      birth_day   <= fin.day;
      region_code <= fin.region;
    end
  end

endmodule

### design/idv_checker.sv
module idv_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic        id_valid,
  input logic        length_ok,
  input logic        chars_ok,
  input logic        date_ok,
  input logic        check_ok,
  input logic [13:0] birth_year,
  input logic [6:0]  birth_month,
  input logic [6:0]  birth_day,
  input logic [19:0] region_code
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result word shown straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(id_valid) &&
      $stable(birth_year) && $stable(region_code) && $stable(check_ok))
    else $error("stalled result word changed");

  a_overall: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> id_valid == (length_ok && chars_ok && date_ok && check_ok))
    else $error("overall verdict disagrees with the partial verdicts");

  a_check_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && check_ok |-> length_ok)
    else $error("check digit accepted on a string of the wrong length");

  a_date: assert property (@(posedge clk) disable iff (rst)
    result_valid && date_ok |-> birth_month >= 7'd1 && birth_month <= 7'd12 &&
      birth_day >= 7'd1 && birth_day <= 7'd31)
    else $error("date accepted outside the calendar");

endmodule

bind id_number_validator_core idv_checker u_idv_checker (.*);
